>>> hw/rtl/ghbp_pkg.sv
// Package with the constants, opcodes and transfer types of the global history branch predictor.
`timescale 1ns / 1ps

package ghbp_pkg;

  localparam int unsigned HistoryBits = 6;
  localparam int unsigned CounterBits = 2;
  localparam int unsigned Threads     = 4;
  localparam int unsigned AddrShift   = 2;
  localparam int unsigned TableSize   = 1 << HistoryBits;

  localparam logic [CounterBits-1:0] CtrMax  = CounterBits'((1 << CounterBits) - 1);
  localparam logic [CounterBits-1:0] CtrHalf = CounterBits'((1 << (CounterBits - 1)) - 1);

  typedef logic [HistoryBits-1:0] hist_t;
  typedef logic [HistoryBits-1:0] idx_t;
  typedef logic [CounterBits-1:0] ctr_t;

  typedef enum logic [2:0] {
    OpLookup        = 3'd0,
    OpUnconditional = 3'd1,
    OpBtbMiss       = 3'd2,
    OpUpdate        = 3'd3,
    OpSquash        = 3'd4
  } opcode_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [1:0]  thread;
    logic [31:0] branch_address;
    logic        taken;
    logic        squashed;
    logic [5:0]  restore_history;
  } req_t;

  typedef struct packed {
    logic       prediction;
    logic [5:0] checkpoint_history;
  } rsp_t;

  typedef struct packed {
    logic en;
    idx_t idx;
    ctr_t data;
  } ctr_wr_t;

endpackage

>>> hw/rtl/global_history_branch_predictor_core.sv
// Top level of the global history branch predictor: per-thread histories and the request pipeline.
`timescale 1ns / 1ps

// One request is taken on every cycle, busy never rises, and each transfer yields exactly one
// result, shown with done_o for one cycle once it has passed the s1_q, s2_q and rsp_q registers. The
// receiver cannot stall, so results must be captured when done_o is high. The pace is set by the
// counter table's registered read: the history a request needs is forwarded from the request one
// stage ahead, and a counter written in the cycle it is read is bypassed into the read register.
module global_history_branch_predictor_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  ghbp_pkg::req_t  req_i,
  output logic            done_o,
  output ghbp_pkg::rsp_t  rsp_o
);
  import ghbp_pkg::*;

  typedef struct packed {
    logic [2:0] opcode;
    logic [1:0] thread;
    logic       taken;
    logic       squashed;
    logic [5:0] restore_history;
    hist_t      hist;
    idx_t       idx;
  } s2_t;

  logic    s1_valid_q;
  req_t    s1_q;
  logic    s2_valid_q;
  s2_t     s2_q;
  logic    done_q;
  rsp_t    rsp_q;
  hist_t   hist_q [Threads];

  hist_t   s1_hist;
  idx_t    s1_idx;
  logic [63:0] s1_addr_sh;
  s2_t     s2_d;

  ctr_t    ctr_rd;
  logic    s2_pred;
  hist_t   s2_hist_next;
  rsp_t    rsp_d;
  ctr_wr_t ctr_wr;

  assign busy = 1'b0;

  // Stage one: effective history of the thread and the table index.
  always_comb begin
    if (s2_valid_q && (s2_q.thread == s1_q.thread)) begin
      s1_hist = s2_hist_next;
    end else begin
      s1_hist = hist_q[s1_q.thread];
    end
    s1_addr_sh = 64'(s1_q.branch_address) << AddrShift;
    s1_idx     = ~(s1_addr_sh[HistoryBits-1:0] & s1_hist);
    s2_d.opcode          = s1_q.opcode;
    s2_d.thread          = s1_q.thread;
    s2_d.taken           = s1_q.taken;
    s2_d.squashed        = s1_q.squashed;
    s2_d.restore_history = s1_q.restore_history;
    s2_d.hist            = s1_hist;
    s2_d.idx             = s1_idx;
  end

  ghbp_counter_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_idx_i  (s1_idx),
    .wr_i      (ctr_wr),
    .rd_data_o (ctr_rd)
  );

  // Stage two: prediction, history update and counter training.
  always_comb begin
    s2_pred      = 1'b0;
    s2_hist_next = s2_q.hist;
    rsp_d        = '0;
    ctr_wr.en    = 1'b0;
    ctr_wr.idx   = s2_q.idx;
    ctr_wr.data  = ctr_rd;
    case (s2_q.opcode)
      OpLookup: begin
        s2_pred                  = (ctr_rd > CtrHalf);
        s2_hist_next             = {s2_q.hist[HistoryBits-2:0], s2_pred};
        rsp_d.prediction         = s2_pred;
        rsp_d.checkpoint_history = s2_q.hist;
      end
      OpUnconditional: begin
        s2_hist_next             = {s2_q.hist[HistoryBits-2:0], 1'b1};
        rsp_d.checkpoint_history = s2_q.hist;
      end
      OpBtbMiss: begin
        s2_hist_next = {s2_q.hist[HistoryBits-1:1], 1'b0};
      end
      OpUpdate: begin
        if (s2_q.squashed) begin
          s2_hist_next = {s2_q.restore_history[HistoryBits-2:0], s2_q.taken};
        end else begin
          ctr_wr.en = s2_valid_q;
          if (s2_q.taken) begin
            if (ctr_rd != CtrMax) begin
              ctr_wr.data = ctr_rd + ctr_t'(1);
            end
          end else begin
            if (ctr_rd != '0) begin
              ctr_wr.data = ctr_rd - ctr_t'(1);
            end
          end
        end
      end
      OpSquash: begin
        s2_hist_next = s2_q.restore_history;
      end
      default: begin
        s2_hist_next = s2_q.hist;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      s1_valid_q <= start && !busy;
      s2_valid_q <= s1_valid_q;
      done_q     <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Threads; i++) begin
        hist_q[i] <= '0;
      end
    end else if (s2_valid_q) begin
      hist_q[s2_q.thread] <= s2_hist_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      s1_q <= req_i;
    end
    s2_q  <= s2_d;
    rsp_q <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

>>> hw/rtl/ghbp_counter_table.sv
// Shared table of saturating counters with a registered read, write bypass and per-entry valid bits.
`timescale 1ns / 1ps

module ghbp_counter_table (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ghbp_pkg::idx_t    rd_idx_i,
  input  ghbp_pkg::ctr_wr_t wr_i,
  output ghbp_pkg::ctr_t    rd_data_o
);
  import ghbp_pkg::*;

  ctr_t                 mem_q [TableSize];
  logic [TableSize-1:0] valid_q;
  ctr_t                 rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.idx] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_i.en) begin
      valid_q[wr_i.idx] <= 1'b1;
    end
  end

  // A write to the entry being read hands its new value straight to the read register.
  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.idx == rd_idx_i)) begin
      rd_data_q <= wr_i.data;
    end else if (valid_q[rd_idx_i]) begin
      rd_data_q <= mem_q[rd_idx_i];
    end else begin
      rd_data_q <= '0;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
